/* design/rtc_bcd_registers_to_epoch_macros.svh */
// Assertion macros for the checker file of the RTC BCD-to-epoch block.
// No dependencies.
`ifndef RTC_BCD_REGISTERS_TO_EPOCH_MACROS_SVH
`define RTC_BCD_REGISTERS_TO_EPOCH_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define RTCBCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RTCBCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rtcbcd_pkg.sv */
// Package for the RTC BCD-to-epoch block: status codes, calendar tables,
// BCD decode. No dependencies.
package rtcbcd_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LOW_VOLT  = 2'd1,
        ST_INVALID   = 2'd2,
        ST_BELOW_MIN = 2'd3
    } t_status;

    localparam logic [15:0] DaysTo2000   = 16'd10957;
    localparam logic [31:0] SecPerDay    = 32'd86400;
    localparam logic [16:0] SecPerHour   = 17'd3600;
    localparam logic [16:0] SecPerMin    = 17'd60;
    localparam logic [31:0] EpochMin2000 = 32'd946684800;
    localparam logic [31:0] EpochMax2099 = 32'd4102444799;

    // hi*10+lo, nibbles not checked
    function automatic logic [7:0] bcd_pair(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // zero for a month outside 1..12
    function automatic logic [4:0] month_len(input logic [4:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: d = 5'd31;
            5'd4, 5'd6, 5'd9, 5'd11:                    d = 5'd30;
            5'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // days before the first of the month, common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/rtc_bcd_registers_to_epoch.sv */
// RTC BCD register snapshot to Unix epoch seconds, four-stage pipeline.
// Throughput one request per cycle while the output is not backpressured.
// Stages: decode/check, day count and time of day, day multiply, minimum compare.
// Any stage holds under output backpressure; bubbles collapse.
// Synchronous active-low reset empties the pipeline and clears r_min_epoch.
// Depends on rtcbcd_pkg.
module rtc_bcd_registers_to_epoch
    import rtcbcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_seconds_byte,
    input  logic [7:0]  i_minutes_byte,
    input  logic [7:0]  i_hours_byte,
    input  logic [7:0]  i_day_byte,
    input  logic [7:0]  i_month_century_byte,
    input  logic [7:0]  i_year_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_epoch_seconds,
    output logic [1:0]  o_status
);

    logic [31:0] r_min_epoch;

    logic en1, en2, en3, en4;
    logic r_vld1, r_vld2, r_vld3, r_vld4;

    // stage 1
    t_status    r_st1, n_st1;
    logic [6:0] r_y2_1, n_y2_1;
    logic [4:0] r_mon1, n_mon1;
    logic [5:0] r_day1, n_day1;
    logic [5:0] r_hr1, n_hr1;
    logic [6:0] r_min1, n_min1;
    logic [6:0] r_sec1, n_sec1;

    // stage 2
    t_status     r_st2;
    logic [15:0] r_days2, n_days2;
    logic [16:0] r_sod2, n_sod2;

    // stage 3
    t_status     r_st3;
    logic [31:0] r_epoch3, n_epoch3;

    // stage 4
    t_status     r_st4, n_st4;
    logic [31:0] r_epoch4, n_epoch4;

    assign en4 = !r_vld4 || i_out_ready;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;

    assign o_in_ready      = en1;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_vld4;
    assign o_epoch_seconds = r_epoch4;
    assign o_status        = r_st4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_epoch <= '0;
        end else if (i_cfg_valid) begin
            r_min_epoch <= i_cfg_data;
        end
    end

    // stage 1: decode and range checks
    always_comb begin
        logic [7:0] yv;
        logic       year_ok;
        logic       leap;
        logic [4:0] dim;
        logic       bad;
        yv      = bcd_pair(i_year_byte);
        year_ok = i_month_century_byte[7] ? (yv >= 8'd100 && yv <= 8'd199)
                                          : (yv <= 8'd99);
        n_y2_1  = i_month_century_byte[7] ? 7'(yv - 8'd100) : yv[6:0];
        n_sec1  = 7'(bcd_pair({1'b0, i_seconds_byte[6:0]}));
        n_min1  = 7'(bcd_pair({1'b0, i_minutes_byte[6:0]}));
        n_hr1   = 6'(bcd_pair({2'b0, i_hours_byte[5:0]}));
        n_day1  = 6'(bcd_pair({2'b0, i_day_byte[5:0]}));
        n_mon1  = 5'(bcd_pair({3'b0, i_month_century_byte[4:0]}));
        leap    = (n_y2_1[1:0] == 2'd0);
        dim     = month_len(n_mon1, leap);
        bad     = !year_ok || (dim == 5'd0) || (n_day1 == 6'd0) || (n_day1 > {1'b0, dim})
                  || (n_hr1 >= 6'd24) || (n_min1 >= 7'd60) || (n_sec1 >= 7'd60);
        if (i_seconds_byte[7]) begin
            n_st1 = ST_LOW_VOLT;
        end else if (bad) begin
            n_st1 = ST_INVALID;
        end else begin
            n_st1 = ST_OK;
        end
    end

    // stage 2: days since 1970 and seconds of day
    always_comb begin
        logic [7:0] leaps;
        logic       adj;
        leaps   = ({1'b0, r_y2_1} + 8'd3) >> 2;
        adj     = (r_y2_1[1:0] == 2'd0) && (r_mon1 > 5'd2);
        n_days2 = DaysTo2000 + 16'(r_y2_1) * 16'd365 + 16'(leaps)
                  + 16'(cum_days(r_mon1[3:0])) + 16'(adj) + 16'(r_day1) - 16'd1;
        n_sod2  = 17'(r_hr1) * SecPerHour + 17'(r_min1) * SecPerMin + 17'(r_sec1);
    end

    // stage 3: scale days
    assign n_epoch3 = 32'(r_days2) * SecPerDay + 32'(r_sod2);

    // stage 4: minimum check and result
    always_comb begin
        n_st4    = r_st3;
        n_epoch4 = '0;
        if (r_st3 == ST_OK) begin
            if (r_epoch3 < r_min_epoch) begin
                n_st4 = ST_BELOW_MIN;
            end else begin
                n_epoch4 = r_epoch3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= i_in_valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
            if (en4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_st1  <= n_st1;
            r_y2_1 <= n_y2_1;
            r_mon1 <= n_mon1;
            r_day1 <= n_day1;
            r_hr1  <= n_hr1;
            r_min1 <= n_min1;
            r_sec1 <= n_sec1;
        end
        if (en2) begin
            r_st2   <= r_st1;
            r_days2 <= n_days2;
            r_sod2  <= n_sod2;
        end
        if (en3) begin
            r_st3    <= r_st2;
            r_epoch3 <= n_epoch3;
        end
        if (en4) begin
            r_st4    <= n_st4;
            r_epoch4 <= n_epoch4;
        end
    end

endmodule

/* design/rtcbcd_sva.sv */
// Port-level checker for rtc_bcd_registers_to_epoch, with its bind.
// Depends on rtcbcd_pkg and rtc_bcd_registers_to_epoch_macros.svh.
`include "rtc_bcd_registers_to_epoch_macros.svh"

module rtcbcd_sva
    import rtcbcd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_epoch_seconds,
    input logic [1:0]  o_status
);

    `RTCBCD_ASSERT(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK) |-> o_epoch_seconds == 32'd0, "non-ok result carries nonzero epoch")

    `RTCBCD_ASSERT(a_ok_range, i_clk, i_rst_n, o_out_valid && (o_status == ST_OK) |-> (o_epoch_seconds >= EpochMin2000) && (o_epoch_seconds <= EpochMax2099), "ok epoch outside 2000..2099")

    `RTCBCD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_epoch_seconds) && $stable(o_status), "stalled result changed")

endmodule

bind rtc_bcd_registers_to_epoch rtcbcd_sva u_rtcbcd_sva (.*);

/* test/rtc_bcd_registers_to_epoch_tb.sv */
// Testbench for rtc_bcd_registers_to_epoch: BCD clock snapshots in, epoch and status out,
// checked in order against a scoreboard that predicts each request.
// Depends on rtcbcd_pkg and the block's RTL.
module rtc_bcd_registers_to_epoch_tb
    import rtcbcd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SettleCycles = 8;
    localparam int HoldCycles   = 120;
    localparam int WatchLimit   = 2000;

    typedef struct packed {
        logic [7:0] sec_b;
        logic [7:0] min_b;
        logic [7:0] hour_b;
        logic [7:0] day_b;
        logic [7:0] mcen_b;
        logic [7:0] year_b;
    } t_rtc_regs;

    typedef struct packed {
        logic [31:0] epoch;
        t_status     status;
    } t_epoch_result;

    class epoch_scoreboard;
        logic [31:0]   floor_epoch;
        t_epoch_result due[$];
        int            faults;

        function new();
            floor_epoch = '0;
            faults = 0;
        endfunction

        function void set_floor(logic [31:0] v);
            floor_epoch = v;
        endfunction

        function int bcd_value(logic [7:0] v);
            return 10 * int'(v[7:4]) + int'(v[3:0]);
        endfunction

        function longint calendar_seconds(int y, int mo, int d, int h, int mi, int s);
            longint yy, era, yoe, mp, doy, doe;
            yy  = y - (mo <= 2 ? 1 : 0);
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = mo > 2 ? mo - 3 : mo + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return (era * 146097 + doe - 719468) * 86400 + h * 3600 + mi * 60 + s;
        endfunction

        function t_epoch_result to_epoch(t_rtc_regs r);
            t_epoch_result res;
            int            s, mi, h, d, mo, y, dim;
            bit            leap;
            longint        secs;
            res.epoch = '0;
            if (r.sec_b[7]) begin
                res.status = ST_LOW_VOLT;
                return res;
            end
            s  = bcd_value({1'b0, r.sec_b[6:0]});
            mi = bcd_value({1'b0, r.min_b[6:0]});
            h  = bcd_value({2'b0, r.hour_b[5:0]});
            d  = bcd_value({2'b0, r.day_b[5:0]});
            mo = bcd_value({3'b0, r.mcen_b[4:0]});
            y  = (r.mcen_b[7] ? 1900 : 2000) + bcd_value(r.year_b);
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (mo)
                4, 6, 9, 11: dim = 30;
                2:           dim = leap ? 29 : 28;
                default:     dim = 31;
            endcase
            if (y < 2000 || y > 2099 || mo < 1 || mo > 12 || d < 1 || d > dim ||
                h > 23 || mi > 59 || s > 59) begin
                res.status = ST_INVALID;
                return res;
            end
            secs = calendar_seconds(y, mo, d, h, mi, s);
            if (secs < longint'(floor_epoch)) begin
                res.status = ST_BELOW_MIN;
                return res;
            end
            res.epoch  = secs[31:0];
            res.status = ST_OK;
            return res;
        endfunction

        function void note_snapshot(t_rtc_regs r);
            due.push_back(to_epoch(r));
        endfunction

        function void check_epoch(logic [31:0] epoch, logic [1:0] status);
            t_epoch_result want;
            if (due.size() == 0) begin
                if (faults < 10)
                    $display("unexpected result: epoch %0d status %0d", epoch, status);
                faults++;
                return;
            end
            want = due.pop_front();
            if (epoch !== want.epoch || status !== want.status) begin
                if (faults < 10)
                    $display("mismatch: expected epoch %0d status %0d, got epoch %0d status %0d",
                             want.epoch, want.status, epoch, status);
                faults++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_seconds_byte;
    logic [7:0]  i_minutes_byte;
    logic [7:0]  i_hours_byte;
    logic [7:0]  i_day_byte;
    logic [7:0]  i_month_century_byte;
    logic [7:0]  i_year_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_epoch_seconds;
    logic [1:0]  o_status;

    epoch_scoreboard sb = new();
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    rtc_bcd_registers_to_epoch u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_seconds_byte      (i_seconds_byte),
        .i_minutes_byte      (i_minutes_byte),
        .i_hours_byte        (i_hours_byte),
        .i_day_byte          (i_day_byte),
        .i_month_century_byte(i_month_century_byte),
        .i_year_byte         (i_year_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_epoch_seconds     (o_epoch_seconds),
        .o_status            (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] to_bcd(int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic t_rtc_regs pack_date(int y, int mo, int d, int h, int mi, int s);
        t_rtc_regs r;
        r.sec_b  = to_bcd(s);
        r.min_b  = to_bcd(mi);
        r.hour_b = to_bcd(h);
        r.day_b  = to_bcd(d);
        r.mcen_b = to_bcd(mo);
        r.year_b = to_bcd(y - 2000);
        return r;
    endfunction

    // mostly well-formed dates with random content, then low-voltage, broken and noise
    function automatic t_rtc_regs random_snapshot();
        t_rtc_regs r;
        int        kind, y, v;
        kind = int'($urandom_range(99));
        y    = int'($urandom_range(2099, 2000));
        r = pack_date(y, int'($urandom_range(12, 1)), int'($urandom_range(31, 1)),
                      int'($urandom_range(23, 0)), int'($urandom_range(59, 0)),
                      int'($urandom_range(59, 0)));
        if ($urandom_range(3) == 0) begin
            r.min_b[7]    = 1'($urandom);
            r.hour_b[7:6] = 2'($urandom);
            r.day_b[7:6]  = 2'($urandom);
            r.mcen_b[6:5] = 2'($urandom);
        end
        if (kind < 6 && y < 2060) begin
            // century flag with a non-decimal year that lands back in 20xx
            v = y - 1900;
            r.mcen_b[7] = 1'b1;
            r.year_b    = {4'(v / 10), 4'(v % 10)};
        end else if (kind < 66) begin
        end else if (kind < 74) begin
            r.sec_b[7] = 1'b1;
        end else if (kind < 88) begin
            case ($urandom_range(5))
                0:       r.sec_b  = 8'($urandom);
                1:       r.min_b  = 8'($urandom);
                2:       r.hour_b = 8'($urandom);
                3:       r.day_b  = 8'($urandom);
                4:       r.mcen_b = 8'($urandom);
                default: r.year_b = 8'($urandom);
            endcase
        end else begin
            r = t_rtc_regs'(48'({$urandom, $urandom}));
        end
        return r;
    endfunction

    task automatic send_snapshot(input t_rtc_regs r);
        int gap;
        gap = 0;
        while (int'($urandom_range(99)) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_seconds_byte       <= r.sec_b;
        i_minutes_byte       <= r.min_b;
        i_hours_byte         <= r.hour_b;
        i_day_byte           <= r.day_b;
        i_month_century_byte <= r.mcen_b;
        i_year_byte          <= r.year_b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        @(posedge i_clk);
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic run_directed();
        t_rtc_regs r;
        send_snapshot(pack_date(2000, 1, 1, 0, 0, 0));
        send_snapshot(pack_date(2099, 12, 31, 23, 59, 59));
        r = pack_date(2024, 5, 6, 7, 8, 9);
        r.sec_b[7] = 1'b1;
        send_snapshot(r);
        send_snapshot(t_rtc_regs'(48'hFFFF_FFFF_FFFF));
        send_snapshot(t_rtc_regs'(48'h0));
        send_snapshot(t_rtc_regs'(48'h8000_0000_0000));
        r = pack_date(2030, 3, 4, 5, 6, 0);
        r.sec_b = 8'h1A;
        send_snapshot(r);
        r.min_b = 8'h5A;
        send_snapshot(r);
        r = pack_date(2024, 6, 15, 12, 0, 0);
        r.mcen_b[7] = 1'b1;
        send_snapshot(r);
        r.year_b = 8'hA5;
        send_snapshot(r);
        r.year_b = 8'hFF;
        send_snapshot(r);
        r.mcen_b[7] = 1'b0;
        send_snapshot(r);
        r.year_b = 8'h9A;
        send_snapshot(r);
        send_snapshot(pack_date(2024, 2, 29, 1, 2, 3));
        send_snapshot(pack_date(2023, 2, 29, 1, 2, 3));
        send_snapshot(pack_date(2000, 2, 29, 1, 2, 3));
        send_snapshot(pack_date(2024, 2, 30, 1, 2, 3));
        send_snapshot(pack_date(2021, 4, 31, 0, 0, 0));
        send_snapshot(pack_date(2021, 13, 1, 0, 0, 0));
        send_snapshot(pack_date(2021, 7, 0, 0, 0, 0));
        send_snapshot(pack_date(2021, 7, 32, 0, 0, 0));
        send_snapshot(pack_date(2021, 7, 4, 24, 0, 0));
        send_snapshot(pack_date(2021, 7, 4, 0, 60, 0));
        send_snapshot(pack_date(2021, 7, 4, 0, 0, 60));
        r = pack_date(2042, 12, 31, 23, 59, 59);
        r.min_b[7]    = 1'b1;
        r.hour_b[7:6] = 2'b11;
        r.day_b[7:6]  = 2'b11;
        r.mcen_b[6:5] = 2'b11;
        send_snapshot(r);
    endtask

    // the floor date is sent as is and, when its seconds are nonzero, one second earlier
    task automatic run_phase(input bit with_directed, input bit floor_off,
                             input int y, input int mo, input int d,
                             input int h, input int mi, input int s,
                             input int tx_pct, input int rx_pct, input int n_items,
                             input bit squeeze);
        drain_pipeline();
        write_floor(floor_off ? 32'd0 : 32'(sb.calendar_seconds(y, mo, d, h, mi, s)));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (with_directed)
            run_directed();
        send_snapshot(pack_date(y, mo, d, h, mi, s));
        if (s > 0)
            send_snapshot(pack_date(y, mo, d, h, mi, s - 1));
        if (squeeze)
            hold_request = 1'b1;
        repeat (n_items) send_snapshot(random_snapshot());
        i_in_valid <= 1'b0;
    endtask

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready <= (int'($urandom_range(99)) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_floor(i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_snapshot({i_seconds_byte, i_minutes_byte, i_hours_byte,
                                  i_day_byte, i_month_century_byte, i_year_byte});
            if (o_out_valid && i_out_ready)
                sb.check_epoch(o_epoch_seconds, o_status);
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchLimit) begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    initial begin
        int ry, rmo, rd, rh, rmi, rs;
        i_rst_n              <= 1'b0;
        i_cfg_valid          <= 1'b0;
        i_cfg_data           <= '0;
        i_in_valid           <= 1'b0;
        i_seconds_byte       <= '0;
        i_minutes_byte       <= '0;
        i_hours_byte         <= '0;
        i_day_byte           <= '0;
        i_month_century_byte <= '0;
        i_year_byte          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(1'b1, 1'b1, 2000, 1, 1, 0, 0, 0, 0, 0, 300, 1'b0);
        run_phase(1'b0, 1'b0, 2000, 1, 1, 0, 0, 0, 62, 0, 300, 1'b0);
        run_phase(1'b0, 1'b0, 2051, 7, 15, 12, 30, 31, 0, 62, 300, 1'b0);
        run_phase(1'b0, 1'b0, 2099, 12, 31, 23, 59, 59, 20, 20, 250, 1'b0);
        run_phase(1'b0, 1'b0, 2024, 2, 29, 6, 7, 8, 0, 0, 300, 1'b1);
        ry  = int'($urandom_range(2099, 2000));
        rmo = int'($urandom_range(12, 1));
        rd  = int'($urandom_range(28, 1));
        rh  = int'($urandom_range(23, 0));
        rmi = int'($urandom_range(59, 0));
        rs  = int'($urandom_range(59, 1));
        run_phase(1'b0, 1'b0, ry, rmo, rd, rh, rmi, rs, 20, 20, 300, 1'b0);
        run_phase(1'b0, 1'b1, 2000, 1, 1, 0, 0, 1, 0, 0, 20, 1'b0);
        drain_pipeline();

        if (sb.faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
